// ===== sv/epoch_to_compact_timestamp_core_defines.svh =====
// Assertion macros shared by the timestamp core.
`ifndef EPOCH_TO_COMPACT_TIMESTAMP_CORE_DEFINES_SVH
`define EPOCH_TO_COMPACT_TIMESTAMP_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ETCT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("etct: check failed in same cycle");

// The consequent must hold in the cycle after the antecedent.
`define ETCT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("etct: check failed in next cycle");

`endif

// ===== sv/etct_pkg.sv =====
package etct_pkg;

    // Load enables of the eight pipeline stages, first stage first.
    typedef struct packed {
        logic st1;
        logic st2;
        logic st3;
        logic st4;
        logic st5;
        logic st6;
        logic st7;
        logic st8;
    } adv_t;

    localparam logic [32:0] SecsPerDay    = 33'd86400;
    // ceil(2^35 / 675); exact quotient for any 25-bit dividend.
    localparam logic [25:0] RecipDay      = 26'd50903317;
    localparam int          RecipDayShift = 35;
    // First day (from 1970) after the nonexistent 2100-02-29.
    localparam logic [15:0] Day2100Mar1   = 16'd47541;
    localparam logic [15:0] YearDays      = 16'd365;
    localparam logic [15:0] QuadDays      = 16'd1461;
    // ceil(2^27 / 1461); exact for any 16-bit dividend.
    localparam logic [16:0] RecipQuad     = 17'd91868;
    localparam logic [16:0] SecsPerHour   = 17'd3600;
    // ceil(2^30 / 3600); exact for any 17-bit dividend.
    localparam logic [18:0] RecipHour     = 19'd298262;
    // ceil(2^18 / 60); exact for any 12-bit dividend.
    localparam logic [12:0] RecipMinute   = 13'd4370;
    localparam logic [11:0] SecsPerMinute = 12'd60;
    localparam logic [11:0] BaseYear      = 12'd1969;
    localparam logic [7:0]  AsciiZero     = 8'h30;
    localparam logic [7:0]  AsciiOne      = 8'h31;
    localparam logic [7:0]  AsciiTwo      = 8'h32;
    localparam logic [7:0]  AsciiNine     = 8'h39;

    // Day of year on which month idx (0 is January) starts.
    function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
        logic [8:0] base;
        case (idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && idx >= 4'd2)
        begin
            base = base + 9'd1;
        end
        return base;
    endfunction

    // Two ASCII digits of a value below 100; v*205 >> 11 is v/10 here.
    function automatic logic [15:0] two_digits(input logic [6:0] v);
        logic [14:0] p;
        logic [3:0]  tens;
        logic [6:0]  ones;
        p    = 15'(v) * 15'd205;
        tens = p[14:11];
        ones = 7'(v - 7'(tens) * 7'd10);
        return {AsciiZero + {4'b0, tens}, AsciiZero + {4'b0, ones[3:0]}};
    endfunction

endpackage

// ===== sv/epoch_to_compact_timestamp_core.sv =====
// Converts seconds since 1970-01-01 UTC, plus a signed zone offset, into a
// Gregorian date and time of day, both as numbers and as the ASCII digits
// YYYYMMDD and hhmmss. The block is an eight-stage pipeline: a word enters
// on every cycle the input is not stalled and its result reaches the
// outputs from the stage 8 register; a stall on the output only holds the
// stages that are full, so empty slots close up before the input is stalled.
// The user must write the zone offset through zone_offset_we only while no
// word is in flight; the block itself does not enforce this.
`include "epoch_to_compact_timestamp_core_defines.svh"

module epoch_to_compact_timestamp_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                zone_offset_we,
    input  logic signed [16:0]  zone_offset,
    input  logic                epoch_valid,
    output logic                epoch_stall,
    input  logic [31:0]         epoch_time,
    output logic                stamp_valid,
    input  logic                stamp_stall,
    output logic [11:0]         cal_year,
    output logic [3:0]          cal_month,
    output logic [4:0]          cal_day,
    output logic [4:0]          clock_hour,
    output logic [5:0]          clock_minute,
    output logic [5:0]          clock_second,
    output logic [63:0]         date_text,
    output logic [47:0]         time_text
);

    logic signed [16:0] offset_reg;
    logic [8:1]         v_reg;
    logic [8:1]         v_next;
    logic [8:1]         adv_vec;
    etct_pkg::adv_t     adv;
    logic [15:0]        days_adj;
    logic [16:0]        day_secs;
    logic [11:0]        year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;

    // A stage may load when it is empty or when the stage after it loads.
    always_comb
    begin
        adv_vec[8] = !v_reg[8] || !stamp_stall;
        for (int k = 7; k >= 1; k--)
        begin
            adv_vec[k] = !v_reg[k] || adv_vec[k + 1];
        end
        v_next[1] = adv_vec[1] ? epoch_valid : v_reg[1];
        for (int k = 2; k <= 8; k++)
        begin
            v_next[k] = adv_vec[k] ? v_reg[k - 1] : v_reg[k];
        end
    end

    assign adv.st1 = adv_vec[1];
    assign adv.st2 = adv_vec[2];
    assign adv.st3 = adv_vec[3];
    assign adv.st4 = adv_vec[4];
    assign adv.st5 = adv_vec[5];
    assign adv.st6 = adv_vec[6];
    assign adv.st7 = adv_vec[7];
    assign adv.st8 = adv_vec[8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            v_reg      <= '0;
        end
        else
        begin
            if (zone_offset_we)
            begin
                offset_reg <= zone_offset;
            end
            v_reg <= v_next;
        end
    end

    assign epoch_stall = !adv_vec[1];
    assign stamp_valid = v_reg[8];

    etct_split u_split (
        .clk         (clk),
        .adv         (adv),
        .epoch_time  (epoch_time),
        .zone_offset (offset_reg),
        .days_adj    (days_adj),
        .day_secs    (day_secs)
    );

    etct_date u_date (
        .clk      (clk),
        .adv      (adv),
        .days_adj (days_adj),
        .year     (year),
        .month    (month),
        .day      (day)
    );

    etct_clock u_clock (
        .clk      (clk),
        .adv      (adv),
        .day_secs (day_secs),
        .hour     (hour),
        .minute   (minute),
        .second   (second)
    );

    etct_text u_text (
        .clk          (clk),
        .adv          (adv),
        .year         (year),
        .month        (month),
        .day          (day),
        .hour         (hour),
        .minute       (minute),
        .second       (second),
        .cal_year     (cal_year),
        .cal_month    (cal_month),
        .cal_day      (cal_day),
        .clock_hour   (clock_hour),
        .clock_minute (clock_minute),
        .clock_second (clock_second),
        .date_text    (date_text),
        .time_text    (time_text)
    );

    `ETCT_ASSERT_NEXT(a_accept_enters, epoch_valid && !epoch_stall, v_reg[1])
    `ETCT_ASSERT_SAME(a_date_range, stamp_valid,
        cal_month >= 4'd1 && cal_month <= 4'd12 && cal_day >= 5'd1)
    `ETCT_ASSERT_SAME(a_clock_range, stamp_valid,
        clock_hour <= 5'd23 && clock_minute <= 6'd59 && clock_second <= 6'd59)

endmodule

// ===== sv/etct_split.sv =====
// Stages 1 to 3: apply the zone offset, then split the time into days and
// seconds of the day. The day count is also shifted so that a 1461-day cycle
// starts on 1969-01-01, with one day skipped after 2100-02-28.
module etct_split (
    input  logic                clk,
    input  etct_pkg::adv_t      adv,
    input  logic [31:0]         epoch_time,
    input  logic signed [16:0]  zone_offset,
    output logic [15:0]         days_adj,
    output logic [16:0]         day_secs
);

    logic [31:0] sum_reg;
    logic [31:0] sum_next;
    logic [50:0] quot_prod;
    logic [15:0] days_reg;
    logic [16:0] lo_reg;
    logic [32:0] day_base;
    logic [15:0] adj_reg;
    logic [15:0] adj_next;
    logic [16:0] secs_reg;
    logic [16:0] secs_next;

    assign sum_next  = epoch_time + {{15{zone_offset[16]}}, zone_offset};
    assign quot_prod = 51'(sum_reg[31:7]) * 51'(etct_pkg::RecipDay);
    assign day_base  = 33'(days_reg) * etct_pkg::SecsPerDay;
    assign secs_next = lo_reg - day_base[16:0];
    assign adj_next  = days_reg + etct_pkg::YearDays
                     + ((days_reg >= etct_pkg::Day2100Mar1) ? 16'd1 : 16'd0);

    always_ff @(posedge clk)
    begin
        if (adv.st1)
        begin
            sum_reg <= sum_next;
        end
        if (adv.st2)
        begin
            days_reg <= quot_prod[etct_pkg::RecipDayShift +: 16];
            lo_reg   <= sum_reg[16:0];
        end
        if (adv.st3)
        begin
            adj_reg  <= adj_next;
            secs_reg <= secs_next;
        end
    end

    assign days_adj = adj_reg;
    assign day_secs = secs_reg;

endmodule

// ===== sv/etct_date.sv =====
// Stages 4 to 7 of the date path: four-year cycle, year within the cycle,
// then month and day of month from the day of year.
module etct_date (
    input  logic            clk,
    input  etct_pkg::adv_t  adv,
    input  logic [15:0]     days_adj,
    output logic [11:0]     year,
    output logic [3:0]      month,
    output logic [4:0]      day
);

    logic [32:0] quad_prod;
    logic [15:0] adj4_reg;
    logic [5:0]  quad4_reg;
    logic [15:0] quad_base;
    logic [10:0] rem_next;
    logic [10:0] rem5_reg;
    logic [5:0]  quad5_reg;
    logic [1:0]  yq;
    logic [8:0]  doy_next;
    logic [8:0]  doy_reg;
    logic        leap_reg;
    logic [7:0]  yoff_reg;
    logic [3:0]  mon_idx;
    logic [8:0]  day_off;
    logic [11:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;

    assign quad_prod = 33'(days_adj) * 33'(etct_pkg::RecipQuad);
    assign quad_base = 16'(quad4_reg) * etct_pkg::QuadDays;
    assign rem_next  = 11'(adj4_reg - quad_base);

    // The leap year is the last of each four-year cycle.
    always_comb
    begin
        if (rem5_reg >= 11'd1095)
        begin
            yq = 2'd3;
        end
        else if (rem5_reg >= 11'd730)
        begin
            yq = 2'd2;
        end
        else if (rem5_reg >= 11'd365)
        begin
            yq = 2'd1;
        end
        else
        begin
            yq = 2'd0;
        end
        doy_next = 9'(rem5_reg - 11'(yq) * 11'd365);
    end

    always_comb
    begin
        mon_idx = 4'd0;
        for (int k = 1; k < 12; k++)
        begin
            if (doy_reg >= etct_pkg::month_start(4'(k), leap_reg))
            begin
                mon_idx = 4'(k);
            end
        end
        day_off = doy_reg - etct_pkg::month_start(mon_idx, leap_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv.st4)
        begin
            adj4_reg  <= days_adj;
            quad4_reg <= quad_prod[32:27];
        end
        if (adv.st5)
        begin
            rem5_reg  <= rem_next;
            quad5_reg <= quad4_reg;
        end
        if (adv.st6)
        begin
            doy_reg  <= doy_next;
            leap_reg <= (yq == 2'd3);
            yoff_reg <= {quad5_reg, 2'b00} + {6'b0, yq};
        end
        if (adv.st7)
        begin
            year_reg  <= etct_pkg::BaseYear + {4'b0, yoff_reg};
            month_reg <= mon_idx + 4'd1;
            day_reg   <= 5'(day_off) + 5'd1;
        end
    end

    assign year  = year_reg;
    assign month = month_reg;
    assign day   = day_reg;

endmodule

// ===== sv/etct_clock.sv =====
// Stages 4 to 7 of the time path: hour, then minute and second.
module etct_clock (
    input  logic            clk,
    input  etct_pkg::adv_t  adv,
    input  logic [16:0]     day_secs,
    output logic [4:0]      hour,
    output logic [5:0]      minute,
    output logic [5:0]      second
);

    logic [35:0] hour_prod;
    logic [16:0] secs4_reg;
    logic [4:0]  hour4_reg;
    logic [16:0] hour_base;
    logic [11:0] rem5_reg;
    logic [4:0]  hour5_reg;
    logic [24:0] min_prod;
    logic [11:0] rem6_reg;
    logic [4:0]  hour6_reg;
    logic [5:0]  min6_reg;
    logic [11:0] min_base;
    logic [4:0]  hour7_reg;
    logic [5:0]  min7_reg;
    logic [5:0]  sec7_reg;

    assign hour_prod = 36'(day_secs) * 36'(etct_pkg::RecipHour);
    assign hour_base = 17'(hour4_reg) * etct_pkg::SecsPerHour;
    assign min_prod  = 25'(rem5_reg) * 25'(etct_pkg::RecipMinute);
    assign min_base  = 12'(min6_reg) * etct_pkg::SecsPerMinute;

    always_ff @(posedge clk)
    begin
        if (adv.st4)
        begin
            secs4_reg <= day_secs;
            hour4_reg <= hour_prod[34:30];
        end
        if (adv.st5)
        begin
            rem5_reg  <= 12'(secs4_reg - hour_base);
            hour5_reg <= hour4_reg;
        end
        if (adv.st6)
        begin
            rem6_reg  <= rem5_reg;
            hour6_reg <= hour5_reg;
            min6_reg  <= min_prod[23:18];
        end
        if (adv.st7)
        begin
            hour7_reg <= hour6_reg;
            min7_reg  <= min6_reg;
            sec7_reg  <= 6'(rem6_reg - min_base);
        end
    end

    assign hour   = hour7_reg;
    assign minute = min7_reg;
    assign second = sec7_reg;

endmodule

// ===== sv/etct_text.sv =====
// Stage 8: output register, with the ASCII digits formed on the way in.
module etct_text (
    input  logic            clk,
    input  etct_pkg::adv_t  adv,
    input  logic [11:0]     year,
    input  logic [3:0]      month,
    input  logic [4:0]      day,
    input  logic [4:0]      hour,
    input  logic [5:0]      minute,
    input  logic [5:0]      second,
    output logic [11:0]     cal_year,
    output logic [3:0]      cal_month,
    output logic [4:0]      cal_day,
    output logic [4:0]      clock_hour,
    output logic [5:0]      clock_minute,
    output logic [5:0]      clock_second,
    output logic [63:0]     date_text,
    output logic [47:0]     time_text
);

    logic [15:0] century;
    logic [6:0]  year_lo;
    logic [63:0] date_next;
    logic [47:0] time_next;
    logic [11:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;
    logic [4:0]  hour_reg;
    logic [5:0]  minute_reg;
    logic [5:0]  second_reg;
    logic [63:0] date_reg;
    logic [47:0] time_reg;

    // Years run from 1970 to 2106, so the first two digits take three forms.
    always_comb
    begin
        if (year >= 12'd2100)
        begin
            century = {etct_pkg::AsciiTwo, etct_pkg::AsciiOne};
            year_lo = 7'(year - 12'd2100);
        end
        else if (year >= 12'd2000)
        begin
            century = {etct_pkg::AsciiTwo, etct_pkg::AsciiZero};
            year_lo = 7'(year - 12'd2000);
        end
        else
        begin
            century = {etct_pkg::AsciiOne, etct_pkg::AsciiNine};
            year_lo = 7'(year - 12'd1900);
        end
        date_next = {century, etct_pkg::two_digits(year_lo),
                     etct_pkg::two_digits({3'b0, month}),
                     etct_pkg::two_digits({2'b0, day})};
        time_next = {etct_pkg::two_digits({2'b0, hour}),
                     etct_pkg::two_digits({1'b0, minute}),
                     etct_pkg::two_digits({1'b0, second})};
    end

    always_ff @(posedge clk)
    begin
        if (adv.st8)
        begin
            year_reg   <= year;
            month_reg  <= month;
            day_reg    <= day;
            hour_reg   <= hour;
            minute_reg <= minute;
            second_reg <= second;
            date_reg   <= date_next;
            time_reg   <= time_next;
        end
    end

    assign cal_year     = year_reg;
    assign cal_month    = month_reg;
    assign cal_day      = day_reg;
    assign clock_hour   = hour_reg;
    assign clock_minute = minute_reg;
    assign clock_second = second_reg;
    assign date_text    = date_reg;
    assign time_text    = time_reg;

endmodule
